@@ hdl/pbin_pkg.sv @@
// ----------------------------------------------------------------------------
// pbin_pkg
// Shared constants, types and helpers for the 2x2 pixel binning block.
// ----------------------------------------------------------------------------
package pbin_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  localparam int DIM_W  = 13;                        // width of the size registers
  localparam int PIX_W  = 16;
  localparam int PAIR_W = PIX_W + 1;
  localparam int SUM_W  = PAIR_W + 1;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);

  localparam int LS_DEPTH = MAX_WIDTH / 2;
  localparam int LS_AW    = $clog2(LS_DEPTH);

  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_WIDE_SAMPLES = 2'd2
  } cfg_idx_t;

  localparam logic [DIM_W-1:0] WIDTH_RST  = DIM_W'(1280);
  localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(960);
  localparam logic [DIM_W-1:0] DIM_MIN    = DIM_W'(2);

  localparam logic [PIX_W-1:0] SAT_NARROW = PIX_W'(255);
  localparam logic [PIX_W-1:0] SAT_WIDE   = PIX_W'(65535);

  // Request from the scan logic to the summing stage
  typedef struct packed {
    logic              valid;
    logic [PAIR_W-1:0] pair;
    logic              last;
    logic              wide;
  } bin_req_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] r;
    r = v;
    if (v < DIM_MIN) begin
      r = DIM_MIN;
    end else if (v > hi) begin
      r = hi;
    end
    return r;
  endfunction

endpackage

@@ hdl/pbin_ram.sv @@
// ----------------------------------------------------------------------------
// pbin_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pbin_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/pbin_scan.sv @@
// ----------------------------------------------------------------------------
// pbin_scan
// Size registers, raster position counters and horizontal pair adder.
// ----------------------------------------------------------------------------
module pbin_scan import pbin_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [DIM_W-1:0]     cfg_wdata,
  input  logic                 in_fire,
  input  logic [PIX_W-1:0]     pixel,
  output logic                 ls_we,
  output logic                 ls_re,
  output logic [LS_AW-1:0]     ls_addr,
  output logic [PAIR_W-1:0]    ls_wdata,
  output bin_req_t             req
);

  logic [DIM_W-1:0] width_r, height_r;
  logic             wide_r;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [PIX_W-1:0] held_r;

  logic [DIM_W-1:0] col_x, row_x;
  logic [DIM_W-1:0] w_even, h_even;
  logic             in_area;
  logic [PAIR_W-1:0] pair;

  // size registers are stored already clamped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      wide_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_FRAME_WIDTH:  width_r  <= clamp_dim(cfg_wdata, DIM_W'(MAX_WIDTH));
        CFG_FRAME_HEIGHT: height_r <= clamp_dim(cfg_wdata, DIM_W'(MAX_HEIGHT));
        CFG_WIDE_SAMPLES: wide_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign col_x   = DIM_W'(col_r);
  assign row_x   = DIM_W'(row_r);
  assign w_even  = {width_r[DIM_W-1:1], 1'b0};
  assign h_even  = {height_r[DIM_W-1:1], 1'b0};
  assign in_area = (col_x < w_even) && (row_x < h_even);
  assign pair    = PAIR_W'(held_r) + PAIR_W'(pixel);

  // odd column closes a pair: even rows store it, odd rows fetch the partner
  assign ls_addr  = col_r[COL_W-1:1];
  assign ls_wdata = pair;
  assign ls_we    = in_fire && in_area && col_r[0] && !row_r[0];
  assign ls_re    = in_fire && in_area && col_r[0] && row_r[0];

  assign req.valid = ls_re;
  assign req.pair  = pair;
  assign req.last  = (row_x == h_even - DIM_W'(1)) && (col_x == w_even - DIM_W'(1));
  assign req.wide  = wide_r;

  // counters wrap at the full size, odd edge included
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_fire) begin
      if (col_x >= width_r - DIM_W'(1)) begin
        col_nxt = '0;
        if (row_x >= height_r - DIM_W'(1)) begin
          row_nxt = '0;
        end else begin
          row_nxt = row_r + ROW_W'(1);
        end
      end else begin
        col_nxt = col_r + COL_W'(1);
        if (row_x >= height_r) begin
          row_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      held_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (in_fire && in_area && !col_r[0]) begin
        held_r <= pixel;
      end
    end
  end

endmodule

@@ hdl/pbin_bin.sv @@
// ----------------------------------------------------------------------------
// pbin_bin
// Adds the stored pair to the odd-row pair, saturates, drives the output word.
// ----------------------------------------------------------------------------
module pbin_bin import pbin_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  bin_req_t          req,
  input  logic [PAIR_W-1:0] ls_rdata,
  output logic              take_ok,
  input  logic              out_tready,
  output logic              out_tvalid,
  output logic [PIX_W-1:0]  out_value,
  output logic              out_last
);

  logic              s1_valid_r;
  logic [PAIR_W-1:0] s1_pair_r;
  logic              s1_last_r;
  logic              s1_wide_r;

  logic              out_valid_r;
  logic [PIX_W-1:0]  out_value_r;
  logic              out_last_r;

  logic              out_free, s1_move;
  logic [SUM_W-1:0]  sum;
  logic [PIX_W-1:0]  limit, sat;

  assign out_free = !out_valid_r || out_tready;
  assign s1_move  = s1_valid_r && out_free;
  assign take_ok  = !s1_valid_r || out_free;

  // line store data lines up with the read stage
  assign sum   = SUM_W'(ls_rdata) + SUM_W'(s1_pair_r);
  assign limit = s1_wide_r ? SAT_WIDE : SAT_NARROW;
  assign sat   = (sum > SUM_W'(limit)) ? limit : sum[PIX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (take_ok) begin
        s1_valid_r <= req.valid;
      end
      if (s1_move) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_ok && req.valid) begin
      s1_pair_r <= req.pair;
      s1_last_r <= req.last;
      s1_wide_r <= req.wide;
    end
    if (s1_move) begin
      out_value_r <= sat;
      out_last_r  <= s1_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_value  = out_value_r;
  assign out_last   = out_last_r;

endmodule

@@ hdl/pixel_bin_2x2_saturating.sv @@
// ----------------------------------------------------------------------------
// pixel_bin_2x2_saturating
// 2x2 pixel binning with saturation to 8 or 16 bits, raster-order stream in.
// ----------------------------------------------------------------------------
//  channel   dir   handshake             payload
//  in_       in    in_tvalid/in_tready   in_tdata: pixel_value
//  out_      out   out_tvalid/out_tready out_tdata: binned_value, out_tlast: frame_end
//  cfg_      in    cfg_we                cfg_addr, cfg_wdata
//
//  One pixel per cycle while in_tready is high. A block's line store read is
//  registered, then add/saturate feeds the output register. in_tready drops
//  only while the output word is stalled and a second result sits in the read
//  stage. Synchronous reset clears counters and the pixel latch; the line
//  store is not cleared, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module pixel_bin_2x2_saturating import pbin_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [PIX_W-1:0]     in_tdata,     // [15:0] pixel_value
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [PIX_W-1:0]     out_tdata,    // [15:0] binned_value
  output logic                 out_tlast,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [DIM_W-1:0]     cfg_wdata
);

  logic              in_fire;
  logic              take_ok;
  logic              ls_we, ls_re;
  logic [LS_AW-1:0]  ls_addr;
  logic [PAIR_W-1:0] ls_wdata, ls_rdata;
  bin_req_t          req;

  assign in_tready = take_ok;
  assign in_fire   = in_tvalid && in_tready;

  pbin_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_fire   (in_fire),
    .pixel     (in_tdata),
    .ls_we     (ls_we),
    .ls_re     (ls_re),
    .ls_addr   (ls_addr),
    .ls_wdata  (ls_wdata),
    .req       (req)
  );

  pbin_ram #(
    .WIDTH (PAIR_W),
    .DEPTH (LS_DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (ls_we),
    .waddr (ls_addr),
    .wdata (ls_wdata),
    .re    (ls_re),
    .raddr (ls_addr),
    .rdata (ls_rdata)
  );

  pbin_bin u_bin (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (req),
    .ls_rdata   (ls_rdata),
    .take_ok    (take_ok),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_value  (out_tdata),
    .out_last   (out_tlast)
  );

endmodule

@@ hdl/pbin_chk.sv @@
// ----------------------------------------------------------------------------
// pbin_chk
// Port-level checks for the binning block, bound to the top level.
// ----------------------------------------------------------------------------
module pbin_chk import pbin_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_tvalid,
  input logic                 in_tready,
  input logic                 out_tvalid,
  input logic                 out_tready,
  input logic [PIX_W-1:0]     out_tdata,
  input logic                 out_tlast,
  input logic                 cfg_we,
  input logic [CFG_IDX_W-1:0] cfg_addr,
  input logic [DIM_W-1:0]     cfg_wdata
);

  logic wide_r;

  // shadow of the sample-width register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wide_r <= 1'b0;
    end else if (cfg_we && (cfg_addr == CFG_WIDE_SAMPLES)) begin
      wide_r <= cfg_wdata[0];
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output word changed while stalled");

  a_narrow_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !wide_r |-> out_tdata[PIX_W-1:8] == '0)
    else $error("eight-bit result above 255");

  a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without output back-pressure");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2))
    else $error("result word without a completing pixel");

endmodule

bind pixel_bin_2x2_saturating pbin_chk u_pbin_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .cfg_we     (cfg_we),
  .cfg_addr   (cfg_addr),
  .cfg_wdata  (cfg_wdata)
);

@@ tb/tb_pixel_bin_2x2_saturating.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pixel_bin_2x2_saturating
// Self-checking bench for the 2x2 binning block. Pixels are streamed in raster
// order. The bench holds its own copy of the line store, the counters and the
// registers, and predicts each binned word and its frame_end flag. Output
// words are matched in order against the predictions. Random idle gaps on
// the input and random stalls on the output are used for most of the run.
// Between the random phases, registers are rewritten at the start of an even row.
// ----------------------------------------------------------------------------

class bin_scoreboard;

  typedef struct {
    logic [pbin_pkg::PIX_W-1:0] value;
    logic                       frame_end;
  } bin_word_t;

  bit [pbin_pkg::PAIR_W-1:0] pair_store [pbin_pkg::LS_DEPTH];
  bit [pbin_pkg::PIX_W-1:0]  held;
  int unsigned               col;
  int unsigned               row;
  bit [pbin_pkg::DIM_W-1:0]  width_reg;
  bit [pbin_pkg::DIM_W-1:0]  height_reg;
  bit                        wide_reg;
  bin_word_t                 expected_bins [$];
  int                        mismatches;

  function new();
    foreach (pair_store[i]) pair_store[i] = '0;
    held       = '0;
    col        = 0;
    row        = 0;
    width_reg  = pbin_pkg::WIDTH_RST;
    height_reg = pbin_pkg::HEIGHT_RST;
    wide_reg   = 1'b0;
    mismatches = 0;
  endfunction

  function void set_reg(pbin_pkg::cfg_idx_t idx, bit [pbin_pkg::DIM_W-1:0] v);
    case (idx)
      pbin_pkg::CFG_FRAME_WIDTH:  width_reg  = v;
      pbin_pkg::CFG_FRAME_HEIGHT: height_reg = v;
      pbin_pkg::CFG_WIDE_SAMPLES: wide_reg   = v[0];
      default: ;
    endcase
  endfunction

  function int unsigned clamped(bit [pbin_pkg::DIM_W-1:0] v, int unsigned hi);
    if (v < pbin_pkg::DIM_MIN) return pbin_pkg::DIM_MIN;
    if (v > hi) return hi;
    return v;
  endfunction

  // Advance the model by one accepted pixel; queue a binned word if one is due
  function void bin_pixel(bit [pbin_pkg::PIX_W-1:0] px);
    int unsigned               w, h, w_even, h_even, sum, limit;
    bit [pbin_pkg::PAIR_W-1:0] pair;
    bin_word_t                 bw;
    w      = clamped(width_reg, pbin_pkg::MAX_WIDTH);
    h      = clamped(height_reg, pbin_pkg::MAX_HEIGHT);
    w_even = w & ~32'd1;
    h_even = h & ~32'd1;
    if (col < w_even && row < h_even) begin
      if (col % 2 == 0) begin
        held = px;
      end else begin
        pair = held + px;
        if (row % 2 == 0) begin
          pair_store[col / 2] = pair;
        end else begin
          sum   = pair_store[col / 2] + pair;
          limit = wide_reg ? pbin_pkg::SAT_WIDE : pbin_pkg::SAT_NARROW;
          if (sum > limit) sum = limit;
          bw.value     = sum[pbin_pkg::PIX_W-1:0];
          bw.frame_end = (row == h_even - 1) && (col == w_even - 1);
          expected_bins.push_back(bw);
        end
      end
    end
    // counters wrap late when a register shrinks under them
    if (col >= w - 1) begin
      col = 0;
      row = (row >= h - 1) ? 0 : row + 1;
    end else begin
      col++;
      if (row >= h) row = 0;
    end
  endfunction

  function void check_word(logic [pbin_pkg::PIX_W-1:0] value, logic frame_end);
    bin_word_t bw;
    if (expected_bins.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected word: value %0d frame_end %b", value, frame_end);
      return;
    end
    bw = expected_bins.pop_front();
    if (value !== bw.value || frame_end !== bw.frame_end) begin
      mismatches++;
      if (mismatches <= 10)
        $display("binned word mismatch: expected value %0d frame_end %b, got %0d %b",
                 bw.value, bw.frame_end, value, frame_end);
    end
  endfunction

endclass

module tb_pixel_bin_2x2_saturating;
  import pbin_pkg::*;

  // index beyond the register list, writes to it are dropped
  localparam cfg_idx_t CFG_SPARE = cfg_idx_t'(2'd3);

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic [PIX_W-1:0]     in_tdata   = '0;
  logic                 out_tready = 1'b0;
  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr   = CFG_FRAME_WIDTH;
  logic [DIM_W-1:0]     cfg_wdata  = '0;
  wire                  in_tready;
  wire                  out_tvalid;
  wire  [PIX_W-1:0]     out_tdata;
  wire                  out_tlast;

  int idle_pct   = 0;
  int stall_pct  = 0;
  int stall_left = 0;
  int pixels_sent = 0;
  bin_scoreboard sb;

  // left edge of the first two lines, hand-picked blocks
  logic [PIX_W-1:0] lead_px [2][10] = '{
    '{16'd0, 16'd0, 16'd63, 16'd64, 16'd64, 16'd64, 16'hFF00, 16'd0, 16'hFFFF, 16'hFFFF},
    '{16'd0, 16'd0, 16'd64, 16'd64, 16'd64, 16'd64, 16'd0,    16'd0, 16'hFFFF, 16'hFFFF}
  };

  pixel_bin_2x2_saturating DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),     // [15:0] pixel_value
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),    // [15:0] binned_value
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  // output side: check accepted words, stall in random bursts
  always @(posedge clk) begin
    if (rst_n && out_tvalid === 1'b1 && out_tready)
      sb.check_word(out_tdata, out_tlast);
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
      stall_left = $urandom_range(10, 1) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  function automatic logic [PIX_W-1:0] pick_pixel(bit wide);
    int r;
    r = $urandom_range(99);
    if (wide) begin
      if (r < 50) return PIX_W'($urandom);
      if (r < 80) return PIX_W'($urandom_range(65535, 49152));
      return PIX_W'($urandom_range(4095));
    end
    // narrow mode: now and then a sample with the upper byte set
    if (r < 80) return PIX_W'($urandom_range(255));
    if (r < 90) return PIX_W'($urandom_range(255, 240));
    return PIX_W'($urandom);
  endfunction

  task automatic send_pixel(logic [PIX_W-1:0] px);
    int gap;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      gap = $urandom_range(10, 1);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= px;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.bin_pixel(px);
    pixels_sent++;
  endtask

  // let the pipeline empty before touching the registers
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.expected_bins.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_one(cfg_idx_t idx, logic [DIM_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    sb.set_reg(idx, v);
  endtask

  // mask bits: width, height, sample mode, spare index
  task automatic program_regs(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h, logic wide,
                              logic [3:0] mask);
    if (mask[0]) write_one(CFG_FRAME_WIDTH, w);
    if (mask[1]) write_one(CFG_FRAME_HEIGHT, h);
    if (mask[2]) write_one(CFG_WIDE_SAMPLES, {{(DIM_W-1){1'b0}}, wide});
    if (mask[3]) write_one(CFG_SPARE, DIM_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  task automatic send_random(int n);
    repeat (n) send_pixel(pick_pixel(sb.wide_reg));
  endtask

  // in the random phases registers only change at the start of an even row, so
  // an odd row never reads a store entry that the row above did not write
  task automatic finish_phase();
    while (!(sb.col == 0 && sb.row % 2 == 0)) send_pixel(pick_pixel(sb.wide_reg));
    drain();
  endtask

  initial begin
    #20_000_000;
    $display("** pixel_bin_2x2_saturating: FAILED **");
    $finish;
  end

  initial begin
    int                start;
    int unsigned       area;
    logic [DIM_W-1:0]  w, h;
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset configuration for the left edge of the first line; the width is
    // then cut to ten so the next line closes the hand-picked blocks
    for (int c = 0; c < 10; c++)
      send_pixel(lead_px[0][c]);
    drain();
    program_regs(10, 0, 1'b0, 4'b0001);
    send_pixel(pick_pixel(1'b0));   // wraps the first line
    for (int c = 0; c < 10; c++)
      send_pixel(lead_px[1][c]);
    drain();

    // sixteen-bit saturation, then a sum of exactly 65535
    program_regs(2, 2, 1'b1, 4'b0111);
    repeat (4) send_pixel(16'hFFFF);
    send_pixel(16'd16384);
    send_pixel(16'd16384);
    send_pixel(16'd16384);
    send_pixel(16'd16383);
    drain();

    // odd width and height: last column and row are dropped
    program_regs(3, 3, 1'b0, 4'b0111);
    send_pixel(16'd255); send_pixel(16'd255); send_pixel(16'hFFFF);
    send_pixel(16'd255); send_pixel(16'd255); send_pixel(16'hFFFF);
    send_pixel(16'hFFFF); send_pixel(16'hFFFF); send_pixel(16'hFFFF);
    drain();

    // sizes below the minimum clamp to 2, plus a write to the spare index
    program_regs(1, 0, 1'b1, 4'b1011);
    send_pixel(16'd1); send_pixel(16'd2); send_pixel(16'd3); send_pixel(16'd4);
    drain();

    // random phases, counters carried across register changes
    start = pixels_sent;
    while (pixels_sent - start < 1000) begin
      case ($urandom_range(2))
        0: idle_pct = 0;
        1: idle_pct = 10;
        default: idle_pct = 40;
      endcase
      case ($urandom_range(2))
        0: stall_pct = 0;
        1: stall_pct = 10;
        default: stall_pct = 40;
      endcase
      case ($urandom_range(9))
        0: w = DIM_W'($urandom_range(1));
        1: w = DIM_W'($urandom_range(48, 17));
        default: w = DIM_W'($urandom_range(16, 2));
      endcase
      case ($urandom_range(9))
        0: h = DIM_W'($urandom_range(1));
        1: h = DIM_W'($urandom_range(16, 9));
        default: h = DIM_W'($urandom_range(8, 2));
      endcase
      program_regs(w, h, 1'($urandom), 4'($urandom_range(15, 1)));
      area = 3 * sb.clamped(sb.width_reg, MAX_WIDTH) * sb.clamped(sb.height_reg, MAX_HEIGHT);
      send_random($urandom_range(area < 150 ? area : 150, 1));
      finish_phase();
    end

    // last part without idling: a wide frame, then one with odd edges
    idle_pct  = 0;
    stall_pct = 0;
    program_regs(40, 6, 1'b1, 4'b0111);
    send_random(240);
    drain();
    program_regs(17, 7, 1'b0, 4'b0111);
    send_random(119);
    drain();

    if (sb.mismatches == 0 && sb.expected_bins.size() == 0) begin
      $display("** pixel_bin_2x2_saturating: PASSED **");
    end else begin
      $display("** pixel_bin_2x2_saturating: FAILED **");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/pbin_pkg.sv
hdl/pbin_ram.sv
hdl/pbin_scan.sv
hdl/pbin_bin.sv
hdl/pixel_bin_2x2_saturating.sv
hdl/pbin_chk.sv
tb/tb_pixel_bin_2x2_saturating.sv
